FILE: design/hrm_pkg.sv
// Shared types and constants of the heartbeat rate monitor.
package hrm_pkg;

	localparam int CHAN_W     = 8;
	localparam int IDX_W      = 3;
	localparam int CNT_W      = 16;
	localparam int AGE_W      = 32;
	localparam int RATE_W     = 24;
	localparam int ACT_W      = 4;
	localparam int PROD_W     = RATE_W + AGE_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int RESULT_LIMIT = 8;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 2'd2;

	localparam logic [AGE_W-1:0]  TIMEOUT_RESET  = 32'd600;
	localparam logic [RATE_W-1:0] MIN_RATE_RESET = 24'd328;
	localparam logic [ACT_W-1:0]  ACTIVE_RESET   = 4'd5;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ARRIVE = 2'd1,
		CMD_REPORT = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		HEALTH_OK         = 2'd0,
		HEALTH_LOW_RATE   = 2'd1,
		HEALTH_TIMEOUT    = 2'd2,
		HEALTH_NEVER_SEEN = 2'd3
	} health_t;

	typedef struct packed {
		cmd_t              command;
		logic [CHAN_W-1:0] channel;
	} cmd_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] channel_index;
		health_t          health_code;
		logic [CNT_W-1:0] window_count;
		logic [AGE_W-1:0] age_ticks;
		logic [AGE_W-1:0] elapsed_ticks;
		logic             last_status;
	} status_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             ready;
		logic             tick;
		logic             arrive;
		logic             mul;
		logic             load;
		logic             last;
		logic             clear;
		logic [IDX_W-1:0] idx;
	} dp_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [ACT_W-1:0] count;
		logic             out_free;
	} dp_status_t;

endpackage

FILE: design/hrm_datapath.sv
// Datapath of the heartbeat rate monitor: channel state, rate product and status register.
module hrm_datapath #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [hrm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [hrm_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic [hrm_pkg::CHAN_W-1:0]            channel,
	input  hrm_pkg::dp_ctrl_t                     ctl,
	output hrm_pkg::dp_status_t                   sts,
	input  logic                                  status_stall,
	output logic                                  status_valid,
	output hrm_pkg::status_item_t                 status_data
);

	localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NLIM  = (MAX_CHANNELS < hrm_pkg::RESULT_LIMIT) ? MAX_CHANNELS
	                       : hrm_pkg::RESULT_LIMIT;
	localparam logic [hrm_pkg::ACT_W-1:0] N_LIMIT = hrm_pkg::ACT_W'(NLIM);

	logic [hrm_pkg::AGE_W-1:0]  timeout_q;
	logic [hrm_pkg::RATE_W-1:0] min_rate_q;
	logic [hrm_pkg::ACT_W-1:0]  active_q;

	logic [hrm_pkg::AGE_W-1:0]  age_q  [MAX_CHANNELS];
	logic [hrm_pkg::CNT_W-1:0]  cnt_q  [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0]    seen_q;
	logic [hrm_pkg::AGE_W-1:0]  elapsed_q;

	logic [hrm_pkg::AGE_W-1:0]  elapsed_eff_q;
	logic [hrm_pkg::PROD_W-1:0] prod_q;

	logic                       out_valid_q;
	hrm_pkg::status_item_t      out_q;

	logic [hrm_pkg::ACT_W-1:0]  n_eff;
	logic                       arr_hit;
	logic [CH_W-1:0]            arr_idx;
	logic [CH_W-1:0]            rd_idx;
	logic [hrm_pkg::AGE_W-1:0]  rd_age;
	logic [hrm_pkg::CNT_W-1:0]  rd_cnt;
	logic                       rd_seen;
	logic                       rate_low;
	hrm_pkg::health_t           code;

	assign n_eff   = (active_q > N_LIMIT) ? N_LIMIT : active_q;
	assign arr_hit = channel < hrm_pkg::CHAN_W'(n_eff);
	assign arr_idx = CH_W'(channel);
	assign rd_idx  = CH_W'(ctl.idx);
	assign rd_age  = age_q[rd_idx];
	assign rd_cnt  = cnt_q[rd_idx];
	assign rd_seen = seen_q[rd_idx];

	assign rate_low = {{(hrm_pkg::PROD_W-hrm_pkg::CNT_W-16){1'b0}}, rd_cnt, 16'h0000} < prod_q;

	always_comb begin
		if (!rd_seen) begin
			code = hrm_pkg::HEALTH_NEVER_SEEN;
		end else if (rd_age > timeout_q) begin
			code = hrm_pkg::HEALTH_TIMEOUT;
		end else if (rate_low) begin
			code = hrm_pkg::HEALTH_LOW_RATE;
		end else begin
			code = hrm_pkg::HEALTH_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= hrm_pkg::TIMEOUT_RESET;
			min_rate_q <= hrm_pkg::MIN_RATE_RESET;
			active_q   <= hrm_pkg::ACTIVE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				hrm_pkg::REG_TIMEOUT:  timeout_q  <= cfg_data;
				hrm_pkg::REG_MIN_RATE: min_rate_q <= cfg_data[hrm_pkg::RATE_W-1:0];
				hrm_pkg::REG_ACTIVE:   active_q   <= cfg_data[hrm_pkg::ACT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				age_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			seen_q    <= '0;
			elapsed_q <= '0;
		end else begin
			if (ctl.tick) begin
				if (elapsed_q != '1) elapsed_q <= elapsed_q + 1'b1;
				for (int i = 0; i < MAX_CHANNELS; i++) begin
					if (age_q[i] != '1) age_q[i] <= age_q[i] + 1'b1;
				end
			end
			if (ctl.arrive && arr_hit) begin
				age_q[arr_idx]  <= '0;
				seen_q[arr_idx] <= 1'b1;
				if (cnt_q[arr_idx] != '1) cnt_q[arr_idx] <= cnt_q[arr_idx] + 1'b1;
			end
			if (ctl.clear) begin
				for (int i = 0; i < MAX_CHANNELS; i++) begin
					cnt_q[i] <= '0;
				end
				elapsed_q <= '0;
			end
		end
	end

	// The elapsed figure is fixed for a whole report, so its product is formed once.
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			elapsed_eff_q <= (elapsed_q == '0) ? hrm_pkg::AGE_W'(1) : elapsed_q;
			prod_q        <= min_rate_q * ((elapsed_q == '0) ? hrm_pkg::AGE_W'(1) : elapsed_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load) begin
			out_valid_q <= 1'b1;
		end else if (!status_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			out_q.channel_index <= ctl.idx;
			out_q.health_code   <= code;
			out_q.window_count  <= rd_cnt;
			out_q.age_ticks     <= rd_seen ? rd_age : '0;
			out_q.elapsed_ticks <= elapsed_eff_q;
			out_q.last_status   <= ctl.last;
		end
	end

	assign sts.count    = n_eff;
	assign sts.out_free = !out_valid_q || !status_stall;
	assign status_valid = out_valid_q;
	assign status_data  = out_q;

endmodule

FILE: design/hrm_ctrl.sv
// Controller state machine of the heartbeat rate monitor.
module hrm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  hrm_pkg::cmd_t       command,
	input  hrm_pkg::dp_status_t sts,
	output hrm_pkg::dp_ctrl_t   ctl
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_WALK = 3'b100
	} state_t;

	state_t                    state_q, state_d;
	logic [hrm_pkg::IDX_W-1:0] idx_q, idx_d;
	logic                      at_last;

	assign at_last = ({1'b0, idx_q} + 4'd1) == sts.count;

	always_comb begin
		ctl     = '0;
		ctl.idx = idx_q;
		state_d = state_q;
		idx_d   = idx_q;
		case (state_q)
			ST_IDLE: begin
				ctl.ready = 1'b1;
				if (cmd_valid) begin
					case (command)
						hrm_pkg::CMD_TICK:   ctl.tick   = 1'b1;
						hrm_pkg::CMD_ARRIVE: ctl.arrive = 1'b1;
						hrm_pkg::CMD_REPORT: begin
							state_d = ST_MUL;
							idx_d   = '0;
						end
						default: ;
					endcase
				end
			end
			ST_MUL: begin
				ctl.mul = 1'b1;
				if (sts.count == '0) begin
					ctl.clear = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.out_free) begin
					ctl.load = 1'b1;
					ctl.last = at_last;
					if (at_last) begin
						ctl.clear = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> sts.out_free)
		else $error("status loaded while the output register is occupied");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.load && ctl.last) |-> ctl.clear)
		else $error("final status of a report without clearing the window");

	a_clear_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> (state_q == ST_IDLE))
		else $error("window cleared but the controller did not return to idle");

	a_mul_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q != ST_MUL))
		else $error("product state held for more than one cycle");

endmodule

FILE: design/heartbeat_rate_monitor_top.sv
// Top level of the multi-channel heartbeat rate monitor.
// Usage: commands enter on the cmd channel (cmd_valid, cmd_stall, cmd_data); a transfer
// happens at a clock edge with cmd_valid high and cmd_stall low. A tick ages every
// channel and the report window by one; an arrival resets the age of its channel and
// bumps its window count, and arrivals on channels outside the active count are dropped.
// Ticks and arrivals can stream at one per clock while no report is in progress.
// A report request produces one status transfer per active channel on the status
// channel (status_valid, status_stall, status_data), lowest channel first, with
// last_status set on the final one. The rate product min_rate_q16 * elapsed is formed
// once per report in the registered multiply state; the walk then loads one channel
// per cycle into the output register while it is free. The first status becomes
// valid once the report has passed the multiply state and the first load into the
// output register; the report holds the block until the final load. While the receiver
// stalls, the output register holds its status and the walk waits. The block takes
// the next command as soon as the final status is loaded, even if it is still unread.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next edge and
// belong in idle periods. Reset sets the registers to their defaults, clears all ages,
// counts, seen flags and the window, and leaves the output empty.
module heartbeat_rate_monitor_top #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hrm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hrm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  hrm_pkg::cmd_item_t             cmd_data,
	output logic                           status_valid,
	input  logic                           status_stall,
	output hrm_pkg::status_item_t          status_data
);

	hrm_pkg::dp_ctrl_t   ctl;
	hrm_pkg::dp_status_t sts;

	// Commands are taken only while the controller is idle, i.e. outside the multiply state and the report walk.
	assign cmd_stall = !ctl.ready;

	hrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (cmd_data.command),
		.sts       (sts),
		.ctl       (ctl)
	);

	hrm_datapath #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.channel      (cmd_data.channel),
		.ctl          (ctl),
		.sts          (sts),
		.status_stall (status_stall),
		.status_valid (status_valid),
		.status_data  (status_data)
	);

endmodule

FILE: sim/hrm_checker.sv
// Checker that predicts and compares the status transfers of the heartbeat rate monitor.
`timescale 1ns / 100ps

module hrm_checker
	import hrm_pkg::*;
#(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  cmd_valid,
	input  logic                  cmd_stall,
	input  cmd_item_t             cmd_data,
	input  logic                  status_valid,
	input  logic                  status_stall,
	input  status_item_t          status_data,
	output int                    fault_count,
	output int                    status_pending,
	output int                    status_checked
);

	// Mirror of the configuration registers.
	logic [AGE_W-1:0]  timeout_limit;
	logic [RATE_W-1:0] min_rate;
	logic [ACT_W-1:0]  active_setting;

	// Mirror of the per-channel liveness state.
	logic [AGE_W-1:0] age_count [MAX_CHANNELS];
	logic [CNT_W-1:0] win_count [MAX_CHANNELS];
	logic             seen      [MAX_CHANNELS];
	logic [AGE_W-1:0] window_ticks;

	status_item_t status_due [$];

	function automatic int unsigned monitored_channels();
		int unsigned n;
		n = 32'(active_setting);
		if (n > MAX_CHANNELS) n = MAX_CHANNELS;
		if (n > RESULT_LIMIT) n = RESULT_LIMIT;
		return n;
	endfunction

	function automatic void flag_fault(string what);
		fault_count++;
		if (fault_count <= 10) $display("[%0t] %s", $realtime, what);
	endfunction

	task automatic apply_command(input cmd_item_t item);
		int unsigned      n;
		logic [AGE_W-1:0] span;
		logic [PROD_W-1:0] needed;
		logic [PROD_W-1:0] have;
		status_item_t     s;
		n = monitored_channels();
		case (item.command)
			CMD_TICK: begin
				if (window_ticks != '1) window_ticks++;
				for (int i = 0; i < MAX_CHANNELS; i++)
					if (age_count[i] != '1) age_count[i]++;
			end
			CMD_ARRIVE: begin
				if (item.channel < n) begin
					age_count[item.channel] = '0;
					if (win_count[item.channel] != '1) win_count[item.channel]++;
					seen[item.channel] = 1'b1;
				end
			end
			CMD_REPORT: begin
				span = (window_ticks == '0) ? AGE_W'(1) : window_ticks;
				needed = PROD_W'(min_rate) * PROD_W'(span);
				for (int i = 0; i < n; i++) begin
					have = PROD_W'({win_count[i], 16'h0000});
					if (!seen[i]) s.health_code = HEALTH_NEVER_SEEN;
					else if (age_count[i] > timeout_limit) s.health_code = HEALTH_TIMEOUT;
					else if (have < needed) s.health_code = HEALTH_LOW_RATE;
					else s.health_code = HEALTH_OK;
					s.channel_index = IDX_W'(i);
					s.window_count  = win_count[i];
					s.age_ticks     = seen[i] ? age_count[i] : '0;
					s.elapsed_ticks = span;
					s.last_status   = (i == n - 1);
					status_due = {status_due, s};
				end
				for (int i = 0; i < MAX_CHANNELS; i++) win_count[i] = '0;
				window_ticks = '0;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		status_item_t want;
		if (!arst_n) begin
			timeout_limit  = TIMEOUT_RESET;
			min_rate       = MIN_RATE_RESET;
			active_setting = ACTIVE_RESET;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				age_count[i] = '0;
				win_count[i] = '0;
				seen[i]      = 1'b0;
			end
			window_ticks = '0;
			status_due.delete();
			fault_count    = 0;
			status_checked = 0;
		end else begin
			if (status_valid && !status_stall) begin
				status_checked++;
				if (status_due.size() == 0) begin
					flag_fault($sformatf("status transfer with none due: ch=%0d code=%0d",
						status_data.channel_index, status_data.health_code));
				end else begin
					want = status_due.pop_front();
					if (status_data.channel_index !== want.channel_index ||
						status_data.health_code !== want.health_code ||
						status_data.window_count !== want.window_count ||
						status_data.age_ticks !== want.age_ticks ||
						status_data.elapsed_ticks !== want.elapsed_ticks ||
						status_data.last_status !== want.last_status)
						flag_fault($sformatf({"status mismatch: expected ch=%0d code=%0d ",
							"count=%0d age=%0d elapsed=%0d last=%0b, got ch=%0d code=%0d ",
							"count=%0d age=%0d elapsed=%0d last=%0b"},
							want.channel_index, want.health_code, want.window_count,
							want.age_ticks, want.elapsed_ticks, want.last_status,
							status_data.channel_index, status_data.health_code,
							status_data.window_count, status_data.age_ticks,
							status_data.elapsed_ticks, status_data.last_status));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT:  timeout_limit  = cfg_data[AGE_W-1:0];
					REG_MIN_RATE: min_rate       = cfg_data[RATE_W-1:0];
					REG_ACTIVE:   active_setting = cfg_data[ACT_W-1:0];
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall) apply_command(cmd_data);
		end
		status_pending = status_due.size();
	end

endmodule

FILE: sim/testbench.sv
// Top of the heartbeat rate monitor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
	import hrm_pkg::*;

	localparam int NUM_CHANNELS = 8;
	// Quiet cycles allowed before the run is declared hung. The longest honest
	// silence is a long sender gap or a few back-to-back receiver stalls.
	localparam int WATCHDOG_LIMIT = 2000;
	// Command code that the block has no use for; it must be dropped silently.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// Register index past the end of the register list; writes must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  cmd_valid    = 1'b0;
	logic                  cmd_stall;
	cmd_item_t             cmd_data     = '0;
	logic                  status_valid;
	logic                  status_stall = 1'b0;
	status_item_t          status_data;

	int fault_count;
	int status_pending;
	int status_checked;

	int n_active       = 5;
	int commands_sent  = 0;
	int settings_used  = 0;
	int calm_left      = 0;
	int stall_hold     = 0;
	logic stall_state  = 1'b0;
	int quiet_cycles   = 0;

	heartbeat_rate_monitor_top #(
		.MAX_CHANNELS(NUM_CHANNELS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd_data    (cmd_data),
		.status_valid(status_valid),
		.status_stall(status_stall),
		.status_data (status_data)
	);

	hrm_checker #(
		.MAX_CHANNELS(NUM_CHANNELS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.cmd_data      (cmd_data),
		.status_valid  (status_valid),
		.status_stall  (status_stall),
		.status_data   (status_data),
		.fault_count   (fault_count),
		.status_pending(status_pending),
		.status_checked(status_checked)
	);

	// 12 ns clock period.
	always #6 clk = ~clk;

	// The receiver alternates between free-running stretches and stalls. Most
	// stalls are short, a few are long enough to back the report walk up.
	always @(negedge clk) begin
		int roll;
		if (stall_hold == 0) begin
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				stall_state = 1'b0;
				stall_hold  = $urandom_range(1, 25);
			end else if (roll < 90) begin
				stall_state = 1'b1;
				stall_hold  = $urandom_range(1, 3);
			end else begin
				stall_state = 1'b1;
				stall_hold  = $urandom_range(8, 40);
			end
		end
		stall_hold--;
		status_stall <= stall_state;
	end

	// The watchdog restarts on every transfer or register write. A status that
	// never shows up also ends here, since the final wait cannot finish then.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (status_valid && !status_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no transfer for %0d cycles, %0d statuses still due",
					$realtime, quiet_cycles, status_pending);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Sender gap before the next command. Mostly back to back, sometimes a few
	// cycles, rarely a long pause; now and then a calm run with no gaps at all.
	function automatic int pick_gap();
		int roll;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 5) calm_left = $urandom_range(10, 30);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Called at a falling edge. Valid stays high after the transfer so that a
	// back-to-back command only changes the payload; a gap lowers it first.
	task automatic send_command(input logic [1:0] code, input logic [CHAN_W-1:0] chan,
		input int gap);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_data  <= cmd_item_t'({code, chan});
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		@(negedge clk);
		commands_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// Registers only change while the block is idle: every due status has been
	// transferred, and a few more cycles let a trailing command settle. The
	// bits above each register's width carry random junk to exercise masking.
	task automatic set_config(input logic [AGE_W-1:0] limit, input logic [RATE_W-1:0] rate,
		input logic [ACT_W-1:0] chans);
		cmd_valid <= 1'b0;
		while (status_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(REG_TIMEOUT, limit);
		write_reg(REG_MIN_RATE, ($urandom & 32'hFF00_0000) | CFG_DATA_W'(rate));
		write_reg(REG_ACTIVE, ($urandom & 32'hFFFF_FFF0) | CFG_DATA_W'(chans));
		write_reg(REG_UNUSED, $urandom);
		cfg_we <= 1'b0;
		n_active = (chans > NUM_CHANNELS) ? NUM_CHANNELS : int'(chans);
		settings_used++;
	endtask

	// Random traffic: mostly arrivals on monitored channels and ticks, with a
	// report every dozen commands or so, plus stray channels and dead codes.
	task automatic random_traffic(input int count);
		int roll;
		logic [CHAN_W-1:0] chan;
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			chan = CHAN_W'($urandom_range(0, 255));
			if (roll < 42) begin
				if (n_active > 0) chan = CHAN_W'($urandom_range(0, n_active - 1));
				send_command(CMD_ARRIVE, chan, pick_gap());
			end else if (roll < 50) begin
				send_command(CMD_ARRIVE, chan, pick_gap());
			end else if (roll < 88) begin
				send_command(CMD_TICK, chan, pick_gap());
			end else if (roll < 96) begin
				send_command(CMD_REPORT, chan, pick_gap());
			end else begin
				send_command(CMD_UNUSED, chan, pick_gap());
			end
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: a report before anything happened shows every channel
		// as never seen with the elapsed count forced up to one. Arrivals on the
		// highest channel and just past the active count are dropped, as is the
		// unused command code. Two reports in a row show the cleared window.
		send_command(CMD_REPORT, 8'h00, 0);
		send_command(CMD_ARRIVE, 8'h00, 0);
		send_command(CMD_ARRIVE, 8'hFF, 0);
		send_command(CMD_ARRIVE, 8'h04, 0);
		send_command(CMD_ARRIVE, 8'h05, 0);
		send_command(CMD_UNUSED, 8'hAA, 0);
		send_command(CMD_TICK, 8'h55, 0);
		send_command(CMD_REPORT, 8'h00, 0);
		send_command(CMD_REPORT, 8'h00, 0);

		// One message per tick with all eight channels: two arrivals over two
		// ticks sits exactly on the rate limit and must read healthy, one arrival
		// falls short. Timeout at its maximum can never fire.
		set_config(32'hFFFF_FFFF, 24'h01_0000, 4'd8);
		send_command(CMD_ARRIVE, 8'h00, 0);
		send_command(CMD_ARRIVE, 8'h00, 0);
		send_command(CMD_ARRIVE, 8'h01, 0);
		send_command(CMD_ARRIVE, 8'h07, 0);
		send_command(CMD_TICK, 8'h00, 0);
		send_command(CMD_TICK, 8'h00, 0);
		send_command(CMD_REPORT, 8'h00, 0);

		// Zero timeout: one tick times out every seen channel, and timeout wins
		// over low rate. A fresh arrival brings the age back to zero, which is
		// not above the limit.
		set_config(32'd0, 24'h01_0000, 4'd8);
		send_command(CMD_TICK, 8'h00, 0);
		send_command(CMD_REPORT, 8'h00, 0);
		send_command(CMD_ARRIVE, 8'h00, 0);
		send_command(CMD_REPORT, 8'h00, 0);

		// Random phases over a spread of settings, extremes included: zero and
		// full-scale rate, zero and maximum timeout, one channel, an active
		// count above the channel limit, and no channels at all.
		set_config(32'd10, 24'd20000, 4'd4);
		random_traffic(60);
		set_config(32'd0, 24'd0, 4'd8);
		random_traffic(50);
		set_config(32'hFFFF_FFFF, 24'hFF_FFFF, 4'd1);
		random_traffic(50);
		set_config(32'd6, 24'd30000, 4'd15);
		random_traffic(60);
		set_config(32'd3, 24'd1000, 4'd0);
		random_traffic(20);
		set_config(AGE_W'($urandom_range(3, 30)), RATE_W'($urandom_range(5000, 40000)),
			ACT_W'($urandom_range(1, 8)));
		random_traffic(60);
		set_config(AGE_W'($urandom_range(3, 30)), RATE_W'($urandom_range(5000, 40000)),
			ACT_W'($urandom_range(1, 8)));
		random_traffic(60);

		cmd_valid <= 1'b0;
		while (status_pending != 0) @(negedge clk);
		repeat (8) @(posedge clk);

		$display("run covered %0d commands across %0d register settings", commands_sent,
			settings_used);
		$display("%0d channel statuses compared, %0d of them wrong", status_checked,
			fault_count);
		if (fault_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
